/* hw/rtl/ssd_pkg.sv */
// Shared types, constants and helpers for the stride stream detector.
// Used by ssd_ctrl, ssd_datapath and stride_stream_detector_unit; no dependencies.
package ssd_pkg;

  localparam int LINE_BYTES = 32;
  localparam int MAX_WINDOW = 16;

  localparam int ADDR_W   = 32;
  localparam int WLEN_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int HIST_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = CNT_W + 1;

  localparam logic [ADDR_W-1:0] LINE_SIZE = ADDR_W'(LINE_BYTES);
  localparam logic [ADDR_W-1:0] LINE_MASK = ~(ADDR_W'(LINE_BYTES) - ADDR_W'(1));
  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;

  localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(8);
  localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(4096);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_LIMIT  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNIT    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OTHER   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH,
    ST_RESULT
  } ssd_state_t;

  typedef struct packed {
    logic load;     // capture the item and clear the scan registers
    logic issue;    // read the next window entry
    logic compare;  // fold the returned entry into min / direction / unit
    logic push;     // append the line and trim the window
    logic result;   // load the output register
  } ssd_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic idx_done;
    logic rd_vld;
    logic hit;
    logic out_free;
  } ssd_stat_t;

  // (a + b) modulo MAX_WINDOW, for a < MAX_WINDOW and b <= MAX_WINDOW
  function automatic logic [HIST_AW-1:0] wrap_add(input logic [HIST_AW-1:0] a,
                                                  input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(MAX_WINDOW)) begin
      s = s - SUM_W'(MAX_WINDOW);
    end
    return HIST_AW'(s);
  endfunction

endpackage

/* hw/rtl/ssd_ctrl.sv */
// Sequencer of the stride stream detector: accept, scan, push, result.
// Depends on ssd_pkg; drives ssd_datapath through ssd_cmd_t.
module ssd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssd_pkg::ssd_stat_t stat,
  output ssd_pkg::ssd_cmd_t  cmd
);
  import ssd_pkg::*;

  ssd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.count_zero ? ST_PUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one read in flight; stop issuing at a unit match
        cmd.compare = stat.rd_vld;
        cmd.issue   = !stat.idx_done && !(stat.rd_vld && stat.hit);
        if (stat.rd_vld && (stat.hit || stat.idx_done)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register can take the item
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ssd_datapath.sv */
// Datapath of the stride stream detector: config registers, miss-line window
// memory, scan compare, window update and output register. Depends on ssd_pkg.
module ssd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssd_pkg::ssd_cmd_t                 cmd,
  output ssd_pkg::ssd_stat_t                stat,
  input  logic                              cfg_write_en,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [ssd_pkg::ADDR_W-1:0]        in_miss_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssd_pkg::STATUS_W-1:0]      out_status,
  output logic [ssd_pkg::ADDR_W-1:0]        out_stride_bytes,
  output logic                              out_ascending,
  output logic [ssd_pkg::ADDR_W-1:0]        out_stream_line,
  output logic [ssd_pkg::ADDR_W-1:0]        out_next_line
);
  import ssd_pkg::*;

  // configuration
  logic [WLEN_W-1:0] wlen_r;
  logic [ADDR_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: wlen_r  <= cfg_data[WLEN_W-1:0];
        CFG_STRIDE_LIMIT:  limit_r <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // window bookkeeping
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [HIST_AW-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   idx_r;
  logic               rd_vld_r;
  logic [ADDR_W-1:0]  rd_data_r;

  // per-item scan registers
  logic [ADDR_W-1:0] line_r;
  logic [CNT_W-1:0]  keep_r;
  logic              empty_r;
  logic [ADDR_W-1:0] min_r;
  logic              up_r;
  logic              unit_r;

  logic [ADDR_W-1:0] hist_mem [MAX_WINDOW];

  logic [HIST_AW-1:0] rd_slot, wr_slot;
  assign rd_slot = wrap_add(oldest_r, idx_r);
  assign wr_slot = wrap_add(oldest_r, count_r);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_mem[wr_slot] <= line_r;
    end
    if (cmd.issue) begin
      rd_data_r <= hist_mem[rd_slot];
    end
  end

  // compare of the returned entry against the new line
  logic              lt;
  logic [ADDR_W-1:0] delta;
  logic              hit;
  assign lt    = line_r < rd_data_r;
  assign delta = lt ? (rd_data_r - line_r) : (line_r - rd_data_r);
  assign hit   = (rd_data_r == line_r - LINE_SIZE) || (rd_data_r == line_r + LINE_SIZE);

  logic [CNT_W-1:0] keep_nxt;
  always_comb begin
    if (int'(wlen_r) > MAX_WINDOW) begin
      keep_nxt = CNT_W'(MAX_WINDOW);
    end else begin
      keep_nxt = CNT_W'(wlen_r);
    end
  end

  // append, then drop the oldest once if the window is too long
  logic [CNT_W-1:0]   cnt1;
  logic [HIST_AW-1:0] old1;
  always_comb begin
    if (count_r < CNT_W'(MAX_WINDOW)) begin
      cnt1 = count_r + CNT_W'(1);
      old1 = oldest_r;
    end else begin
      cnt1 = count_r;
      old1 = wrap_add(oldest_r, CNT_W'(1));
    end
    if (cnt1 > keep_r) begin
      count_nxt  = cnt1 - CNT_W'(1);
      oldest_nxt = wrap_add(old1, CNT_W'(1));
    end else begin
      count_nxt  = cnt1;
      oldest_nxt = old1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      oldest_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.push) begin
        count_r  <= count_nxt;
        oldest_r <= oldest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_r  <= in_miss_address & LINE_MASK;
      empty_r <= (count_r == '0);
      keep_r  <= (count_r == '0) ? CNT_W'(MAX_WINDOW) : keep_nxt;
      min_r   <= ALL_ONES;
      up_r    <= 1'b1;
      unit_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.compare) begin
        up_r <= !lt;
        if (delta < min_r) begin
          min_r <= delta;
        end
        if (hit) begin
          unit_r <= 1'b1;
        end
      end
    end
  end

  // result formation
  logic [ADDR_W-1:0]   stride;
  logic                ignore;
  logic [STATUS_W-1:0] status_nxt;
  assign stride = unit_r ? LINE_SIZE : min_r;
  assign ignore = (stride == '0) || (stride == ALL_ONES) || (stride > limit_r);

  always_comb begin
    if (empty_r) begin
      status_nxt = STAT_EMPTY;
    end else if (ignore) begin
      status_nxt = STAT_IGNORED;
    end else if (unit_r) begin
      status_nxt = STAT_UNIT;
    end else begin
      status_nxt = STAT_OTHER;
    end
  end

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   stride_r, sline_r, nline_r;
  logic                asc_r;
  logic                stream;
  assign stream = !empty_r && !ignore;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      status_r <= status_nxt;
      stride_r <= stream ? stride : '0;
      asc_r    <= stream && up_r;
      sline_r  <= stream ? line_r : '0;
      nline_r  <= !stream ? '0 : (up_r ? line_r + stride : line_r - stride);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_stride_bytes = stride_r;
  assign out_ascending    = asc_r;
  assign out_stream_line  = sline_r;
  assign out_next_line    = nline_r;

  assign stat.count_zero = (count_r == '0);
  assign stat.idx_done   = (idx_r == count_r);
  assign stat.rd_vld     = rd_vld_r;
  assign stat.hit        = hit;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

/* hw/rtl/stride_stream_detector_unit.sv */
// Top level of the stride stream detector: sequencer plus datapath.
// Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_miss_address
//   out      output     out_valid / out_stall  out_status, out_stride_bytes, out_ascending,
//                                              out_stream_line, out_next_line
//   cfg      input      cfg_write_en           cfg_index, cfg_data
//
// An item is compared against N window entries between accept and result, N being the
// number of entries held (at most 16), fewer on a unit match; the window
// memory is read one entry per cycle through a registered read port. A miss on an
// empty window skips the scan. Reset is synchronous and active low; it empties the
// window and restores the register defaults. A stalled result holds in the output
// register, and the next item is taken only after it has been loaded there.
module stride_stream_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ssd_pkg::ADDR_W-1:0]     in_miss_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssd_pkg::STATUS_W-1:0]   out_status,
  output logic [ssd_pkg::ADDR_W-1:0]     out_stride_bytes,
  output logic                           out_ascending,
  output logic [ssd_pkg::ADDR_W-1:0]     out_stream_line,
  output logic [ssd_pkg::ADDR_W-1:0]     out_next_line,
  input  logic                           cfg_write_en,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssd_pkg::*;

  ssd_cmd_t  cmd;
  ssd_stat_t stat;

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_miss_address  (in_miss_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_stride_bytes (out_stride_bytes),
    .out_ascending    (out_ascending),
    .out_stream_line  (out_stream_line),
    .out_next_line    (out_next_line)
  );

endmodule

/* tb/sv/tb_stride_stream_detector_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stride_stream_detector_unit: directed rows, then random miss streams.
// Depends on ssd_pkg and the detector RTL; results are checked against a local predictor or directed rows.
module tb_stride_stream_detector_unit;
  import ssd_pkg::*;

  localparam int PHASE_ITEMS = 145;
  localparam int NUM_PHASES  = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   stride_bytes;
    logic                ascending;
    logic [ADDR_W-1:0]   stream_line;
    logic [ADDR_W-1:0]   next_line;
  } stride_report_t;

  typedef enum logic [1:0] {
    ROW_MISS,
    ROW_CHECK,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [ADDR_W-1:0]    value;
    stride_report_t       want;
  } stim_row_t;

  localparam stride_report_t NO_REPORT      = '0;
  localparam stride_report_t EMPTY_REPORT   = '{STAT_EMPTY, 32'h0, 1'b0, 32'h0, 32'h0};
  localparam stride_report_t IGNORED_REPORT = '{STAT_IGNORED, 32'h0, 1'b0, 32'h0, 32'h0};

  localparam int NUM_ROWS = 29;
  localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{ROW_CHECK, CFG_WINDOW_LENGTH, 32'h0000_0000, EMPTY_REPORT},
    '{ROW_CHECK, CFG_WINDOW_LENGTH, 32'h0000_003F,
      '{STAT_UNIT, 32'h20, 1'b1, 32'h0000_0020, 32'h0000_0040}},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0005, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_1000, NO_REPORT},
    '{ROW_CHECK, CFG_WINDOW_LENGTH, 32'h0000_1000, IGNORED_REPORT},
    '{ROW_CHECK, CFG_WINDOW_LENGTH, 32'h8000_0000, IGNORED_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hFFFF_FFFF, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0010, NO_REPORT},
    '{ROW_CFG,   CFG_STRIDE_LIMIT,  32'h0000_0000, NO_REPORT},
    '{ROW_CHECK, CFG_WINDOW_LENGTH, 32'h0000_0040, IGNORED_REPORT},
    '{ROW_CFG,   CFG_STRIDE_LIMIT,  32'hFFFF_FFFF, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h7FFF_FFE0, NO_REPORT},
    '{ROW_CFG,   CFG_WINDOW_LENGTH, 32'h0000_0000, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h1234_5678, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h1234_5698, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0000, NO_REPORT},
    '{ROW_CFG,   CFG_WINDOW_LENGTH, 32'h0000_001F, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hAAAA_AAAA, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h5555_5555, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hAAAA_AAC0, NO_REPORT},
    '{ROW_CFG,   CFG_WINDOW_LENGTH, 32'h0000_0001, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hDEAD_BEE0, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hDEAD_BF00, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'hDEAD_BEC0, NO_REPORT},
    '{ROW_CFG,   CFG_WINDOW_LENGTH, 32'h0000_0010, NO_REPORT},
    '{ROW_CFG,   CFG_STRIDE_LIMIT,  32'h0000_0020, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0100, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0160, NO_REPORT},
    '{ROW_MISS,  CFG_WINDOW_LENGTH, 32'h0000_0140, NO_REPORT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     in_miss_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_stride_bytes;
  logic                  out_ascending;
  logic [ADDR_W-1:0]     out_stream_line;
  logic [ADDR_W-1:0]     out_next_line;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: window of miss lines, oldest entry at window_head
  logic [ADDR_W-1:0] window_lines [MAX_WINDOW];
  int unsigned       window_fill = 0;
  int unsigned       window_head = 0;
  logic [WLEN_W-1:0] window_length = WLEN_RESET;
  logic [ADDR_W-1:0] stride_limit = LIMIT_RESET;

  stride_report_t expected_reports [$];

  int mismatch_count = 0;
  int miss_count = 0;
  int setting_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int burst_left = 0;
  logic [9:0] stall_tick = '0;

  // random stream generator state
  logic [ADDR_W-1:0] stream_base = '0;
  int                stream_stride = LINE_BYTES;
  int                stream_step = 0;
  int                stream_left = 0;
  logic [ADDR_W-1:0] last_address = '0;

  stride_stream_detector_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_miss_address  (in_miss_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_stride_bytes (out_stride_bytes),
    .out_ascending    (out_ascending),
    .out_stream_line  (out_stream_line),
    .out_next_line    (out_next_line),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall: quiet, sparse random, periodic and dense stretches in turn
  always @(negedge clk) begin
    case (stall_tick[9:8])
      2'd0: out_stall = 1'b0;
      2'd1: out_stall = ($urandom_range(0, 2) == 0);
      2'd2: out_stall = (stall_tick[3:0] < 4'd7);
      default: out_stall = ($urandom_range(0, 3) != 0);
    endcase
    stall_tick = stall_tick + 10'd1;
  end

  function automatic void append_line(input logic [ADDR_W-1:0] line, input int unsigned keep);
    window_lines[(window_head + window_fill) % MAX_WINDOW] = line;
    if (window_fill < MAX_WINDOW) begin
      window_fill++;
    end else begin
      window_head = (window_head + 1) % MAX_WINDOW;
    end
    // trim at most one entry per miss
    if (window_fill > keep) begin
      window_head = (window_head + 1) % MAX_WINDOW;
      window_fill--;
    end
  endfunction

  function automatic stride_report_t predict_stride(input logic [ADDR_W-1:0] miss_address);
    logic [ADDR_W-1:0] line;
    logic [ADDR_W-1:0] entry;
    logic [ADDR_W-1:0] delta;
    logic [ADDR_W-1:0] min_delta;
    logic [ADDR_W-1:0] stride;
    int unsigned       keep;
    logic              unit;
    logic              up;
    stride_report_t    rep;
    line = miss_address & LINE_MASK;
    keep = (window_length > MAX_WINDOW) ? MAX_WINDOW : int'(window_length);
    min_delta = ALL_ONES;
    unit = 1'b0;
    up = 1'b1;
    rep = '0;
    if (window_fill == 0) begin
      append_line(line, MAX_WINDOW);
      rep.status = STAT_EMPTY;
      return rep;
    end
    for (int i = 0; i < window_fill; i++) begin
      entry = window_lines[(window_head + i) % MAX_WINDOW];
      if (line < entry) begin
        up = 1'b0;
        delta = entry - line;
      end else begin
        up = 1'b1;
        delta = line - entry;
      end
      if (delta < min_delta) min_delta = delta;
      // stop at a neighbor exactly one line away, with 32-bit wrap
      if (entry == line - LINE_SIZE || entry == line + LINE_SIZE) begin
        unit = 1'b1;
        break;
      end
    end
    append_line(line, keep);
    stride = unit ? LINE_SIZE : min_delta;
    if (stride == '0 || stride == ALL_ONES || stride > stride_limit) begin
      rep.status = STAT_IGNORED;
      return rep;
    end
    rep.status = unit ? STAT_UNIT : STAT_OTHER;
    rep.stride_bytes = stride;
    rep.ascending = up;
    rep.stream_line = line;
    rep.next_line = up ? line + stride : line - stride;
    return rep;
  endfunction

  function automatic logic [ADDR_W-1:0] next_miss_address();
    int unsigned pick;
    int          lines;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (stream_left == 0 || pick < 4) begin
      if ($urandom_range(0, 3) == 0) begin
        stream_base = ($urandom_range(0, 1) ? 32'hFFFF_F000 : 32'h0) + $urandom_range(0, 4095);
      end else begin
        stream_base = $urandom;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: lines = 1;
        5, 6, 7:       lines = $urandom_range(2, 64);
        default:       lines = $urandom_range(65, 300);
      endcase
      stream_stride = ($urandom_range(0, 1) ? lines : -lines) * LINE_BYTES;
      stream_step = 0;
      stream_left = $urandom_range(4, 24);
    end
    if (pick < 75) begin
      addr = (stream_base & LINE_MASK) + ADDR_W'(stream_stride * stream_step)
             + ADDR_W'($urandom_range(0, LINE_BYTES - 1));
      stream_step++;
      stream_left--;
    end else if (pick < 88) begin
      addr = last_address ^ ADDR_W'($urandom_range(0, 2 * LINE_BYTES - 1));
    end else begin
      addr = $urandom;
    end
    last_address = addr;
    return addr;
  endfunction

  task automatic send_miss(input logic [ADDR_W-1:0] addr, input logic typed,
                           input stride_report_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_miss_address = addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    miss_count++;
    if (typed) begin
      void'(predict_stride(addr));
      expected_reports = {expected_reports, want};
    end else begin
      expected_reports = {expected_reports, predict_stride(addr)};
    end
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = sel;
    cfg_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
    case (sel)
      CFG_WINDOW_LENGTH: window_length = value[WLEN_W-1:0];
      CFG_STRIDE_LIMIT:  stride_limit = value;
      default: ;
    endcase
    setting_count++;
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    stride_report_t got;
    stride_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_stride_bytes, out_ascending, out_stream_line, out_next_line};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected item: expected none, got status %0d stride %h line %h",
                 $time, got.status, got.stride_bytes, got.stream_line);
        mismatch_count++;
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        check_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
        check_field("stride_bytes", want.stride_bytes, got.stride_bytes);
        check_field("ascending", ADDR_W'(want.ascending), ADDR_W'(got.ascending));
        check_field("stream_line", want.stream_line, got.stream_line);
        check_field("next_line", want.next_line, got.next_line);
        if (!$isunknown(got.status)) status_seen[got.status]++;
      end
    end
  end

  initial begin
    logic [WLEN_W-1:0] phase_length [NUM_PHASES];
    logic [ADDR_W-1:0] phase_limit [NUM_PHASES];
    phase_length = '{5'd8, 5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd12, 5'd3};
    phase_limit = '{32'd4096, 32'hFFFF_FFFF, $urandom, 32'd1024, 32'd8192,
                    32'hFFFF_FFFF, 32'd256, $urandom, 32'd32, 32'd0};
    for (int i = 0; i < MAX_WINDOW; i++) window_lines[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      case (DIRECTED_ROWS[r].kind)
        ROW_CFG: begin
          drain_results();
          write_register(DIRECTED_ROWS[r].reg_sel, DIRECTED_ROWS[r].value);
        end
        ROW_CHECK: send_miss(DIRECTED_ROWS[r].value, 1'b1, DIRECTED_ROWS[r].want);
        default: send_miss(DIRECTED_ROWS[r].value, 1'b0, NO_REPORT);
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_register(CFG_WINDOW_LENGTH, CFG_DATA_W'(phase_length[p]));
      write_register(CFG_STRIDE_LIMIT, phase_limit[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_miss(next_miss_address(), 1'b0, NO_REPORT);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d misses across %0d register writes", miss_count, setting_count);
    $display("Reports: %0d empty, %0d ignored, %0d unit stride, %0d other stride",
             status_seen[STAT_EMPTY], status_seen[STAT_IGNORED],
             status_seen[STAT_UNIT], status_seen[STAT_OTHER]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
